/* sv/brra_pkg.sv */
package brra_pkg;

   localparam int FIELD_BITS     = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   // workload codes, the fourth code is unused
   localparam logic [1:0] FUNC_ACTOR   = 2'd0;
   localparam logic [1:0] FUNC_SECTION = 2'd1;
   localparam logic [1:0] FUNC_ENTITY  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_ACTOR_BUDGET  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENTITY_BUDGET = 1'b1;

   localparam logic [FIELD_BITS-1:0] BUDGET_RESET = 16'd64;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* sv/brra_if.sv */
interface brra_req_if import brra_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [FIELD_BITS-1:0] eligible_count;
   logic [FIELD_BITS-1:0] queue_budget;

   modport source (output valid, func, eligible_count, queue_budget, input ready);
   modport sink   (input valid, func, eligible_count, queue_budget, output ready);
endinterface

interface brra_rsp_if import brra_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] admitted_count;
   logic [FIELD_BITS-1:0] deferred_count;
   logic [FIELD_BITS-1:0] window_ticks;
   logic [FIELD_BITS-1:0] first_index;

   modport source (output valid, admitted_count, deferred_count, window_ticks,
                   first_index, input ready);
   modport sink   (input valid, admitted_count, deferred_count, window_ticks,
                   first_index, output ready);
endinterface

/* sv/budgeted_round_robin_admission.sv */
// Budgeted round-robin admission planner. Each request names a workload and its eligible
// count; the block returns admitted = min(count, budget), deferred = count - admitted,
// window = ceil(count / budget) (0 when count or budget is 0) and the first index. The
// actor and entity workloads take their budget from csr registers 0 and 1 (reset 64)
// and keep a start pointer each, reduced modulo the count and advanced with wrap; the
// section workload uses the budget carried in the request and reports first index 0.
// Workload code 3 is accepted and dropped with no response. The shared restoring divider
// runs one quotient bit per cycle, first for the pointer modulo and then for the window;
// a division that is not needed is skipped. The response sits in an output register,
// so the next request is taken while a finished response waits.
module budgeted_round_robin_admission import brra_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   brra_req_if.sink                  req_if,
   brra_rsp_if.source                rsp_if,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int W = COUNT_BITS;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_MOD    = 5'b00100,
      ST_WIN    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [FIELD_BITS-1:0] actor_budget_ff, entity_budget_ff;

   // rotating pointers, entry 0 actors and entry 1 entities
   logic [W-1:0] ptr_ff [2];
   logic [W-1:0] ptr_in [2];

   // transaction context
   logic         rotating_ff, rotating_in;
   logic         slot_ff, slot_in;
   logic [W-1:0] count_ff, count_in;
   logic [W-1:0] budget_ff, budget_in;
   logic [W-1:0] admitted_ff, admitted_in;
   logic [W-1:0] first_ff, first_in;
   logic [W-1:0] window_ff, window_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_admitted_ff, rsp_admitted_in;
   logic [FIELD_BITS-1:0] rsp_deferred_ff, rsp_deferred_in;
   logic [FIELD_BITS-1:0] rsp_window_ff, rsp_window_in;
   logic [FIELD_BITS-1:0] rsp_first_ff, rsp_first_in;

   // request decode
   logic                  req_accept;
   logic                  func_known;
   logic [31:0]           elig_wide;
   logic [FIELD_BITS-1:0] budget_field;
   logic [31:0]           budget_wide;
   logic [W-1:0]          count_new, budget_new;

   // shared divider
   logic         div_start;
   logic         use_mod;
   logic [W-1:0] div_dividend, div_divisor;
   logic [W-1:0] div_quo, div_rem;
   div_stat_type div_stat;

   logic         count_nz, budget_nz;
   logic         rsp_load;
   logic [W:0]   wrap_sum, wrap_diff;
   logic [W-1:0] wrapped;
   logic [31:0]  adm_wide, def_wide, win_wide, first_wide;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign func_known   = (req_if.func == FUNC_ACTOR) || (req_if.func == FUNC_SECTION) ||
                         (req_if.func == FUNC_ENTITY);

   always_comb begin
      priority if (req_if.func == FUNC_ACTOR)  budget_field = actor_budget_ff;
      else if (req_if.func == FUNC_ENTITY)     budget_field = entity_budget_ff;
      else                                     budget_field = req_if.queue_budget;
   end

   // counts and budgets live at COUNT_BITS
   assign elig_wide   = 32'(req_if.eligible_count);
   assign budget_wide = 32'(budget_field);
   assign count_new   = elig_wide[W-1:0];
   assign budget_new  = budget_wide[W-1:0];

   assign count_nz  = (count_ff != '0);
   assign budget_nz = (budget_ff != '0);

   // pointer modulo first, then the window division
   assign use_mod      = (state_ff == ST_SETUP) && rotating_ff && count_nz;
   assign div_dividend = use_mod ? ptr_ff[slot_ff] : count_ff - W'(1);
   assign div_divisor  = use_mod ? count_ff : budget_ff;

   brra_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   // first < count and admitted <= count, so one subtract wraps the sum
   assign wrap_sum  = {1'b0, first_ff} + {1'b0, admitted_ff};
   assign wrap_diff = wrap_sum - {1'b0, count_ff};
   assign wrapped   = wrap_diff[W] ? wrap_sum[W-1:0] : wrap_diff[W-1:0];

   assign adm_wide   = 32'(admitted_ff);
   assign def_wide   = 32'(count_ff - admitted_ff);
   assign win_wide   = 32'(window_ff);
   assign first_wide = 32'(first_ff);

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in        = state_ff;
      rotating_in     = rotating_ff;
      slot_in         = slot_ff;
      count_in        = count_ff;
      budget_in       = budget_ff;
      admitted_in     = admitted_ff;
      first_in        = first_ff;
      window_in       = window_ff;
      ptr_in          = ptr_ff;
      div_start       = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_admitted_in = rsp_admitted_ff;
      rsp_deferred_in = rsp_deferred_ff;
      rsp_window_in   = rsp_window_ff;
      rsp_first_in    = rsp_first_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // unused workload code is taken and dropped
            if (req_accept && func_known) begin
               rotating_in = (req_if.func != FUNC_SECTION);
               slot_in     = (req_if.func == FUNC_ENTITY);
               count_in    = count_new;
               budget_in   = budget_new;
               admitted_in = (count_new < budget_new) ? count_new : budget_new;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            first_in = '0;
            if (rotating_ff && count_nz) begin
               div_start = 1'b1;
               state_in  = ST_MOD;
            end else if (count_nz && budget_nz) begin
               div_start = 1'b1;
               state_in  = ST_WIN;
            end else begin
               window_in = '0;
               state_in  = ST_FINISH;
            end
         end
         ST_MOD: begin
            if (div_stat.done) begin
               first_in = div_rem;
               if (budget_nz) begin
                  div_start = 1'b1;
                  state_in  = ST_WIN;
               end else begin
                  window_in = '0;
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_WIN: begin
            if (div_stat.done) begin
               window_in = div_quo + W'(1);
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in    = 1'b1;
               rsp_admitted_in = adm_wide[FIELD_BITS-1:0];
               rsp_deferred_in = def_wide[FIELD_BITS-1:0];
               rsp_window_in   = win_wide[FIELD_BITS-1:0];
               rsp_first_in    = first_wide[FIELD_BITS-1:0];
               if (rotating_ff) begin
                  ptr_in[slot_ff] = count_nz ? wrapped : '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         actor_budget_ff  <= BUDGET_RESET;
         entity_budget_ff <= BUDGET_RESET;
         ptr_ff[0]        <= '0;
         ptr_ff[1]        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_ACTOR_BUDGET:  actor_budget_ff  <= csr_data;
               REG_ENTITY_BUDGET: entity_budget_ff <= csr_data;
               default: ;
            endcase
         end
      end
      rotating_ff     <= rotating_in;
      slot_ff         <= slot_in;
      count_ff        <= count_in;
      budget_ff       <= budget_in;
      admitted_ff     <= admitted_in;
      first_ff        <= first_in;
      window_ff       <= window_in;
      rsp_admitted_ff <= rsp_admitted_in;
      rsp_deferred_ff <= rsp_deferred_in;
      rsp_window_ff   <= rsp_window_in;
      rsp_first_ff    <= rsp_first_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.admitted_count = rsp_admitted_ff;
   assign rsp_if.deferred_count = rsp_deferred_ff;
   assign rsp_if.window_ticks   = rsp_window_ff;
   assign rsp_if.first_index    = rsp_first_ff;

   // a response only appears out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   // the divider is never restarted while it runs
   a_div_not_busy: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // divider results only land while the sequencer waits for them
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_MOD || state_ff == ST_WIN))
      else $error("divider finished outside a wait state");

   // the reduced pointer and the advanced pointer stay below the count
   a_first_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rotating_ff && count_nz) |-> (first_ff < count_ff))
      else $error("first index not below count");

   a_ptr_below: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rotating_ff && count_nz) |=> (ptr_ff[$past(slot_ff)] < $past(count_ff)))
      else $error("start pointer not below count");

endmodule

/* sv/brra_div.sv */
module brra_div import brra_pkg::*; #(
   parameter int W = COUNT_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder,
   output div_stat_type stat
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   // one restoring step per cycle, one quotient bit each
   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;

endmodule
